// File: rtl/core/kwpm_pkg.sv
// ----------------------------------------------------------------------------
// kwpm_pkg
// Shared widths, codes and controller/datapath handshake types for the
// kernel window page mapper.
// ----------------------------------------------------------------------------
package kwpm_pkg;

   // Window geometry
   localparam int WINDOW_PAGES = 1024;
   localparam int IDX_W        = (WINDOW_PAGES > 1) ? $clog2(WINDOW_PAGES) : 1;
   localparam int POS_W        = $clog2(WINDOW_PAGES + 1);
   localparam int CNT_W        = 12;
   localparam int CMP_W        = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

   // Field widths
   localparam int CMD_W    = 2;
   localparam int ADDR_W   = 32;
   localparam int SIZE_W   = 23;
   localparam int STATUS_W = 2;
   localparam int PAGE_W   = 20;
   localparam int OFS_W    = 12;
   localparam int ENTRY_W  = PAGE_W + 1;
   localparam int SUM_W    = SIZE_W + 1;

   localparam logic [PAGE_W-1:0] BASE_RESET = 20'hD0000;
   localparam logic [OFS_W-1:0]  OFS_ROUND  = 12'hFFF;

   // Commands
   localparam logic [CMD_W-1:0] CMD_MAP   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_UNMAP = 2'd1;
   localparam logic [CMD_W-1:0] CMD_XLATE = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNMAPPED = 2'd2;

   // Register port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic REG_WINDOW_BASE = 1'b0;

   // Controller -> datapath
   typedef struct packed {
      logic clear_step;
      logic accept;
      logic scan_step;
      logic fill_step;
      logic unmap_step;
      logic look_rd;
      logic look_chk;
      logic map_ok;
      logic map_fail;
      logic done_zero;
      logic publish;
   } kwpm_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic is_map;
      logic is_unmap;
      logic is_xlate;
      logic count_zero;
      logic count_big;
      logic scan_hit;
      logic scan_end;
      logic step_last;
      logic rsp_free;
   } kwpm_stat_type;

endpackage

// File: rtl/core/kwpm_if.sv
// ----------------------------------------------------------------------------
// kwpm_req_if / kwpm_rsp_if
// Valid/ready channels for mapper requests and results.
// ----------------------------------------------------------------------------
interface kwpm_req_if import kwpm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [ADDR_W-1:0] addr;
   logic [SIZE_W-1:0] size_bytes;

   modport source (output valid, cmd, addr, size_bytes, input ready);
   modport sink   (input valid, cmd, addr, size_bytes, output ready);
endinterface

interface kwpm_rsp_if import kwpm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   result_addr;

   modport source (output valid, status, result_addr, input ready);
   modport sink   (input valid, status, result_addr, output ready);
endinterface

// File: rtl/core/kernel_window_page_mapper.sv
// ----------------------------------------------------------------------------
// kernel_window_page_mapper
// Top level: first-fit page mapper over a window of 4 KiB page entries.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time. After reset it runs a clearing
// pass through every page table entry and holds req_bus.ready low until it
// ends; register writes are taken throughout. A map walks the table one
// entry per cycle from the window base through a single-port read with
// registered data, up to the end of the first free run (at most
// WINDOW_PAGES entries), then writes the run's pages one at a time. Unmap
// clears each page in the range in turn, translate reads one entry and then
// checks it, and a zero-page map or unmap, an oversized map or the unused
// command go from decode straight to the final state. A map that finds no
// run answers after a full scan. The next transaction can be accepted in the
// same cycle that the result appears; while the output register holds a
// result that has not been taken, the block waits in its final state. A
// finished result sits in that output register while the next transaction
// is accepted.
// ----------------------------------------------------------------------------
module kernel_window_page_mapper import kwpm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   kwpm_req_if.sink          req_bus,
   kwpm_rsp_if.source        rsp_bus,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   kwpm_cmd_type  cmd;
   kwpm_stat_type stat;
   logic          req_ready;

   assign req_bus.ready = req_ready;

   kwpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   kwpm_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_cmd        (req_bus.cmd),
      .req_addr       (req_bus.addr),
      .req_size_bytes (req_bus.size_bytes),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_bus        (rsp_bus),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

endmodule

// File: rtl/core/kwpm_ctrl.sv
// ----------------------------------------------------------------------------
// kwpm_ctrl
// Sequencer for the page mapper: clearing pass, decode, first-fit scan,
// fill, unmap sweep, lookup and result hand-off.
// ----------------------------------------------------------------------------
module kwpm_ctrl import kwpm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  kwpm_stat_type stat,
   output kwpm_cmd_type  cmd
);

   typedef enum logic [7:0] {
      S_CLEAR  = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_DECODE = 8'b0000_0100,
      S_SCAN   = 8'b0000_1000,
      S_FILL   = 8'b0001_0000,
      S_UNMAP  = 8'b0010_0000,
      S_CHECK  = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.is_map) begin
               if (stat.count_zero) begin
                  cmd.map_ok = 1'b1;
                  state_in   = S_DONE;
               end else if (stat.count_big) begin
                  cmd.map_fail = 1'b1;
                  state_in     = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end else if (stat.is_unmap) begin
               if (stat.count_zero) begin
                  cmd.done_zero = 1'b1;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_UNMAP;
               end
            end else if (stat.is_xlate) begin
               cmd.look_rd = 1'b1;
               state_in    = S_CHECK;
            end else begin
               cmd.done_zero = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_hit) begin
               state_in = S_FILL;
            end else if (stat.scan_end) begin
               cmd.map_fail = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_FILL: begin
            cmd.fill_step = 1'b1;
            if (stat.step_last) begin
               cmd.map_ok = 1'b1;
               state_in   = S_DONE;
            end
         end
         S_UNMAP: begin
            cmd.unmap_step = 1'b1;
            if (stat.step_last) begin
               cmd.done_zero = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_CHECK: begin
            cmd.look_chk = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            // hold until the output register can take the result
            if (stat.rsp_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

// File: rtl/core/kwpm_dp.sv
// ----------------------------------------------------------------------------
// kwpm_dp
// Datapath of the page mapper: page table memory, request registers, scan
// and step counters, window base register and result registers.
// ----------------------------------------------------------------------------
module kwpm_dp import kwpm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [ADDR_W-1:0]  req_addr,
   input  logic [SIZE_W-1:0]  req_size_bytes,
   input  kwpm_cmd_type       cmd,
   output kwpm_stat_type      stat,
   kwpm_rsp_if.source         rsp_bus,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [CSR_AW-1:0]  csr_paddr,
   input  logic [CSR_DW-1:0]  csr_pwdata,
   output logic [CSR_DW-1:0]  csr_prdata,
   output logic               csr_pready
);

   // Page table
   logic [ENTRY_W-1:0] entries_ff [WINDOW_PAGES];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               wr_en;

   // Request and sequencing registers
   logic [PAGE_W-1:0]   base_ff;
   logic [CMD_W-1:0]    cmd_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [IDX_W-1:0]    clr_ff;
   logic [POS_W-1:0]    pos_ff;
   logic                data_vld_ff;
   logic [IDX_W-1:0]    data_idx_ff;
   logic [POS_W-1:0]    run_ff;
   logic [IDX_W-1:0]    start_ff;
   logic [CNT_W-1:0]    step_ff;

   // Result registers
   logic [STATUS_W-1:0] pend_status_ff;
   logic [ADDR_W-1:0]   pend_addr_ff;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;

   logic [SUM_W-1:0]  span_sum;
   logic [CNT_W-1:0]  count_in;
   logic [PAGE_W-1:0] look_rel;
   logic [PAGE_W-1:0] unmap_rel;
   logic [PAGE_W-1:0] step_page;
   logic              look_in_win;
   logic              unmap_in_win;
   logic              entry_free;
   logic [CMP_W-1:0]  run_next;
   logic              scan_hit;
   logic [IDX_W-1:0]  hit_start;
   logic              pos_live;
   logic              csr_wr;

   // Pages spanned by the request
   assign span_sum = SUM_W'(req_addr[OFS_W-1:0]) + SUM_W'(req_size_bytes) + SUM_W'(OFS_ROUND);
   assign count_in = (req_size_bytes == '0) ? '0 : span_sum[SUM_W-1:OFS_W];

   assign step_page    = PAGE_W'(step_ff);
   assign look_rel     = addr_ff[ADDR_W-1:OFS_W] - base_ff;
   assign unmap_rel    = addr_ff[ADDR_W-1:OFS_W] + step_page - base_ff;
   assign look_in_win  = (look_rel < PAGE_W'(WINDOW_PAGES));
   assign unmap_in_win = (unmap_rel < PAGE_W'(WINDOW_PAGES));

   // First-fit run tracking on the registered read data
   assign entry_free = !rd_data_ff[PAGE_W];
   assign run_next   = CMP_W'(run_ff) + CMP_W'(1);
   assign scan_hit   = data_vld_ff && entry_free && (run_next >= CMP_W'(count_ff));
   assign hit_start  = IDX_W'(CMP_W'(data_idx_ff) + CMP_W'(1) - CMP_W'(count_ff));
   assign pos_live   = (pos_ff < POS_W'(WINDOW_PAGES));

   // Memory ports
   assign rd_addr = cmd.look_rd ? look_rel[IDX_W-1:0] : pos_ff[IDX_W-1:0];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_data = '0;
      if (cmd.clear_step) begin
         wr_en = 1'b1;
      end else if (cmd.fill_step) begin
         wr_en   = 1'b1;
         wr_addr = IDX_W'(CMP_W'(start_ff) + CMP_W'(step_ff));
         wr_data = {1'b1, addr_ff[ADDR_W-1:OFS_W] + step_page};
      end else if (cmd.unmap_step) begin
         // drop pages that fall outside the window
         wr_en   = unmap_in_win;
         wr_addr = unmap_rel[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) entries_ff[wr_addr] <= wr_data;
      rd_data_ff <= entries_ff[rd_addr];
   end

   // Control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         data_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= BASE_RESET;
      end else begin
         if (cmd.clear_step) clr_ff <= clr_ff + IDX_W'(1);
         if (cmd.accept) begin
            data_vld_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            data_vld_ff <= pos_live;
         end
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr) base_ff <= csr_pwdata[PAGE_W-1:0];
      end
   end

   // Request, scan and result payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff   <= req_cmd;
         addr_ff  <= req_addr;
         count_ff <= count_in;
         pos_ff   <= '0;
         run_ff   <= '0;
         start_ff <= '0;
         step_ff  <= '0;
      end else begin
         if (cmd.scan_step) begin
            if (pos_live) pos_ff <= pos_ff + POS_W'(1);
            data_idx_ff <= pos_ff[IDX_W-1:0];
            if (data_vld_ff) run_ff <= entry_free ? POS_W'(run_next) : '0;
            if (scan_hit) begin
               start_ff <= hit_start;
               step_ff  <= '0;
            end
         end
         if (cmd.fill_step || cmd.unmap_step) step_ff <= step_ff + CNT_W'(1);
      end

      if (cmd.map_ok) begin
         pend_status_ff <= STATUS_OK;
         pend_addr_ff   <= {base_ff + PAGE_W'(start_ff), addr_ff[OFS_W-1:0]};
      end else if (cmd.map_fail) begin
         pend_status_ff <= STATUS_FULL;
         pend_addr_ff   <= '0;
      end else if (cmd.done_zero) begin
         pend_status_ff <= STATUS_OK;
         pend_addr_ff   <= '0;
      end else if (cmd.look_chk) begin
         if (look_in_win && rd_data_ff[PAGE_W]) begin
            pend_status_ff <= STATUS_OK;
            pend_addr_ff   <= {rd_data_ff[PAGE_W-1:0], addr_ff[OFS_W-1:0]};
         end else begin
            pend_status_ff <= STATUS_UNMAPPED;
            pend_addr_ff   <= '0;
         end
      end

      if (cmd.publish) begin
         rsp_status_ff <= pend_status_ff;
         rsp_addr_ff   <= pend_addr_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.result_addr = rsp_addr_ff;

   // Status to the controller
   always_comb begin
      stat            = '0;
      stat.clear_last = (clr_ff == IDX_W'(WINDOW_PAGES - 1));
      stat.is_map     = (cmd_ff == CMD_MAP);
      stat.is_unmap   = (cmd_ff == CMD_UNMAP);
      stat.is_xlate   = (cmd_ff == CMD_XLATE);
      stat.count_zero = (count_ff == '0);
      stat.count_big  = (CMP_W'(count_ff) > CMP_W'(WINDOW_PAGES));
      stat.scan_hit   = scan_hit;
      stat.scan_end   = data_vld_ff && !scan_hit &&
                        (data_idx_ff == IDX_W'(WINDOW_PAGES - 1));
      stat.step_last  = (step_ff == count_ff - CNT_W'(1));
      stat.rsp_free   = !rsp_valid_ff || rsp_bus.ready;
   end

   // Register port
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == REG_WINDOW_BASE);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_WINDOW_BASE) ? CSR_DW'(base_ff) : '0;

endmodule
